// ----- hdl/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the positional list store: payload structs,
// operation and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SET    = 2'd2,
		OP_GET    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       operation;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} in_item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] read_value;
		logic [POS_W-1:0]          entry_count;
	} out_item_t;

	typedef enum logic [1:0] {
		RD_AT   = 2'd0,
		RD_PREV = 2'd1,
		RD_NEXT = 2'd2
	} rd_sel_t;

	typedef enum logic {
		WR_SHIFT = 1'b0,
		WR_VAL   = 1'b1
	} wr_sel_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    idx_from_count;
		logic    idx_from_at;
		logic    idx_inc;
		logic    idx_dec;
		logic    rv_capture;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    st_set;
		status_t st_code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		op_t  operation;
		logic full;
		logic range_err;
		logic idx_gt_at;
		logic idx_last;
		logic out_busy;
	} sts_t;

endpackage

// ----- hdl/positional_list_store_unit.sv -----
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered store of signed 32-bit values addressed by position, with insert,
// remove, set and get operations and one result per operation.
//
//   Channel   Direction   Handshake               Payload
//   in        input       in_valid / in_ready     pls_pkg::in_item_t
//   out       output      out_valid / out_ready   pls_pkg::out_item_t
//
// Set and every rejected operation finish without a memory read; get reads
// its entry, remove reads and captures its entry, and every entry that moves
// needs one read and one write of the entry memory. Reset clears the entry
// count and the output register's valid; entry contents are not cleared. A
// new transfer is taken while a result still waits; a stalled output holds
// the following result in the datapath.
// ----------------------------------------------------------------------------
module positional_list_store_unit #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pls_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pls_pkg::out_item_t out_data
);
	import pls_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pls_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- hdl/pls_ctrl.sv -----
// ----------------------------------------------------------------------------
// pls_ctrl
// Controller of the positional list store. Sequences one operation at a time
// and moves entries one by one through the datapath's entry memory.
// ----------------------------------------------------------------------------
module pls_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pls_pkg::sts_t sts,
	output pls_pkg::cmd_t cmd
);
	import pls_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_INS_CHK,
		S_INS_WR,
		S_RM_CAP,
		S_RM_CHK,
		S_RM_WR,
		S_GET_CAP,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.operation == OP_INSERT) begin
					if (sts.full) begin
						cmd.st_set  = 1'b1;
						cmd.st_code = ST_FULL;
						state_nx    = S_FINISH;
					end else begin
						cmd.idx_from_count = 1'b1;
						state_nx           = S_INS_CHK;
					end
				end else if (sts.range_err) begin
					cmd.st_set  = 1'b1;
					cmd.st_code = ST_RANGE;
					state_nx    = S_FINISH;
				end else if (sts.operation == OP_REMOVE) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_AT;
					state_nx   = S_RM_CAP;
				end else if (sts.operation == OP_SET) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WR_VAL;
					state_nx   = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_AT;
					state_nx   = S_GET_CAP;
				end
			end
			S_INS_CHK: begin
				if (sts.idx_gt_at) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_nx   = S_INS_WR;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_VAL;
					cmd.cnt_inc = 1'b1;
					state_nx    = S_FINISH;
				end
			end
			S_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.idx_dec = 1'b1;
				state_nx    = S_INS_CHK;
			end
			S_RM_CAP: begin
				cmd.rv_capture  = 1'b1;
				cmd.idx_from_at = 1'b1;
				state_nx        = S_RM_CHK;
			end
			S_RM_CHK: begin
				if (!sts.idx_last) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_nx   = S_RM_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_nx    = S_FINISH;
				end
			end
			S_RM_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.idx_inc = 1'b1;
				state_nx    = S_RM_CHK;
			end
			S_GET_CAP: begin
				cmd.rv_capture = 1'b1;
				state_nx       = S_FINISH;
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ----- hdl/pls_dpath.sv -----
// ----------------------------------------------------------------------------
// pls_dpath
// Datapath of the positional list store: entry memory, entry count, walking
// index, item registers and the output register.
// ----------------------------------------------------------------------------
module pls_dpath #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pls_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pls_pkg::out_item_t out_data,
	input  pls_pkg::cmd_t      cmd,
	output pls_pkg::sts_t      sts
);
	import pls_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > POS_W) ? CW : POS_W;

	logic [VALUE_W-1:0] mem [CAPACITY];

	op_t                op_q;
	logic [VALUE_W-1:0] val_q;
	logic [CW-1:0]      at_q;
	logic               full_q;
	logic               range_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [VALUE_W-1:0] rdata_q;
	logic [VALUE_W-1:0] rv_q;
	status_t            st_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [EW-1:0] pos_ext;
	logic [EW-1:0] cnt_ext;
	logic [CW-1:0] idx_prev;
	logic [CW-1:0] idx_next;
	logic [CW:0]   idx_next_w;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [VALUE_W-1:0] wr_data;

	assign pos_ext    = EW'(in_data.position);
	assign cnt_ext    = EW'(cnt_q);
	assign idx_prev   = idx_q - CW'(1);
	assign idx_next   = idx_q + CW'(1);
	assign idx_next_w = {1'b0, idx_q} + (CW + 1)'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_AT:   rd_addr = at_q[AW-1:0];
			RD_PREV: rd_addr = idx_prev[AW-1:0];
			RD_NEXT: rd_addr = idx_next[AW-1:0];
			default: rd_addr = at_q[AW-1:0];
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_SHIFT: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = rdata_q;
			end
			WR_VAL: begin
				wr_addr = at_q[AW-1:0];
				wr_data = val_q;
			end
			default: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = rdata_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_data.operation;
			val_q   <= in_data.value;
			full_q  <= (cnt_q >= CW'(CAPACITY));
			range_q <= (pos_ext >= cnt_ext);
			at_q    <= (pos_ext < cnt_ext) ? CW'(pos_ext) : cnt_q;
		end
		if (cmd.idx_from_count) begin
			idx_q <= cnt_q;
		end else if (cmd.idx_from_at) begin
			idx_q <= at_q;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_next;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_prev;
		end
		if (cmd.load) begin
			rv_q <= '0;
		end else if (cmd.rv_capture) begin
			rv_q <= rdata_q;
		end
		if (cmd.load) begin
			st_q <= ST_OK;
		end else if (cmd.st_set) begin
			st_q <= cmd.st_code;
		end
		if (cmd.out_load) begin
			out_q.status      <= st_q;
			out_q.read_value  <= rv_q;
			out_q.entry_count <= cnt_ext[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.operation = op_q;
	assign sts.full      = full_q;
	assign sts.range_err = range_q;
	assign sts.idx_gt_at = (idx_q > at_q);
	assign sts.idx_last  = (idx_next_w >= {1'b0, cnt_q});
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- tb/positional_list_store_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_unit_tb
// Self-checking testbench for the positional list store. A shadow copy of the
// store predicts every result as each input transfer is taken, and each output
// transfer is checked field by field against the oldest prediction. Directed
// tests cover the empty store, front and append inserts, the full store and
// front/back removal. A long random walk then fills and drains the store
// repeatedly, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module positional_list_store_unit_tb;

	import pls_pkg::*;

	localparam int CAPACITY   = CAPACITY_DEF;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 100;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
	int                        shadow_count;
	out_item_t                 pending_results [$];

	bit steady;
	int stall_len;
	int fails;
	int idle_cycles;
	int n_ops;
	int n_full;
	int n_range;
	int peak_count;

	positional_list_store_unit #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		fails++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	function automatic out_item_t predict_result(input in_item_t item);
		out_item_t res;
		int at;
		int p;
		int i;
		p = int'(item.position);
		res.status = ST_OK;
		res.read_value = '0;
		if (item.operation == OP_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				at = (p < shadow_count) ? p : shadow_count;
				for (i = shadow_count; i > at; i--) begin
					shadow_entries[i] = shadow_entries[i-1];
				end
				shadow_entries[at] = item.value;
				shadow_count++;
			end
		end else if (p >= shadow_count) begin
			res.status = ST_RANGE;
		end else begin
			case (item.operation)
				OP_REMOVE: begin
					res.read_value = shadow_entries[p];
					for (i = p; i + 1 < shadow_count; i++) begin
						shadow_entries[i] = shadow_entries[i+1];
					end
					shadow_count--;
				end
				OP_SET: begin
					shadow_entries[p] = item.value;
				end
				default: begin
					res.read_value = shadow_entries[p];
				end
			endcase
		end
		res.entry_count = POS_W'(shadow_count);
		return res;
	endfunction

	// Results are checked before the same edge's input is predicted.
	always @(posedge clk) begin
		out_item_t exp_res;
		out_item_t new_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d %0d %0d",
					out_data.status, out_data.read_value, out_data.entry_count));
			end else begin
				exp_res = pending_results.pop_front();
				if (out_data.status !== exp_res.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						out_data.status, exp_res.status));
				if (out_data.read_value !== exp_res.read_value)
					report_mismatch($sformatf("read_value got %0d expected %0d",
						out_data.read_value, exp_res.read_value));
				if (out_data.entry_count !== exp_res.entry_count)
					report_mismatch($sformatf("entry_count got %0d expected %0d",
						out_data.entry_count, exp_res.entry_count));
			end
		end
		if (arst_n && in_valid && in_ready) begin
			new_res = predict_result(in_data);
			pending_results.push_back(new_res);
			n_ops++;
			if (new_res.status == ST_FULL) n_full++;
			if (new_res.status == ST_RANGE) n_range++;
			if (shadow_count > peak_count) peak_count = shadow_count;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_len > 0) begin
				out_ready <= 1'b0;
				stall_len--;
			end else begin
				out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 12);
			end
		end
	end

	task automatic send_op(input in_item_t item);
		while (!steady && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_fields(input op_t op, input logic signed [VALUE_W-1:0] val,
			input int pos);
		in_item_t item;
		item.operation = op;
		item.value = val;
		item.position = POS_W'(pos);
		send_op(item);
	endtask

	function automatic in_item_t random_op(input bit grow);
		in_item_t item;
		int pick;
		int r;
		pick = $urandom_range(99);
		if (grow) begin
			if (pick < 60) item.operation = OP_INSERT;
			else if (pick < 75) item.operation = OP_REMOVE;
			else if (pick < 88) item.operation = OP_SET;
			else item.operation = OP_GET;
		end else begin
			if (pick < 20) item.operation = OP_INSERT;
			else if (pick < 70) item.operation = OP_REMOVE;
			else if (pick < 85) item.operation = OP_SET;
			else item.operation = OP_GET;
		end
		r = $urandom_range(9);
		if (r < 7) item.position = POS_W'($urandom_range(shadow_count));
		else if (r < 9) item.position = POS_W'($urandom_range(CAPACITY));
		else item.position = POS_W'($urandom_range(31));
		r = $urandom_range(15);
		case (r)
			0: item.value = 32'sh8000_0000;
			1: item.value = 32'sh7fff_ffff;
			2: item.value = '0;
			3: item.value = -32'sd1;
			default: item.value = $urandom;
		endcase
		return item;
	endfunction

	task automatic test_empty_store();
		send_fields(OP_REMOVE, 32'sd5, 0);
		send_fields(OP_SET, 32'sd7, 0);
		send_fields(OP_GET, 32'sd0, 0);
		send_fields(OP_INSERT, 32'sd0, 31);
	endtask

	task automatic test_insert_positions();
		send_fields(OP_INSERT, 32'sh8000_0000, 0);
		send_fields(OP_INSERT, 32'sh7fff_ffff, 16);
		send_fields(OP_INSERT, -32'sd1, 1);
		send_fields(OP_GET, 32'sd0, 3);
	endtask

	task automatic test_full_store();
		int i;
		for (i = 0; i < CAPACITY - 4; i++) begin
			send_fields(OP_INSERT, $urandom, $urandom_range(i + 4));
		end
		send_fields(OP_INSERT, 32'sh1234_5678, 2);
		send_fields(OP_GET, 32'sd0, CAPACITY);
	endtask

	task automatic test_set_remove();
		send_fields(OP_SET, 32'shaaaa_aaaa, 0);
		send_fields(OP_REMOVE, 32'sd0, CAPACITY - 1);
		send_fields(OP_REMOVE, 32'sh5555_5555, 0);
	endtask

	task automatic test_random_walk(input int n_items);
		int i;
		bit grow;
		grow = 1'b0;
		for (i = 0; i < n_items; i++) begin
			if (i % 90 == 0) grow = !grow;
			steady = (i >= 300 && i < 500);
			send_op(random_op(grow));
		end
		steady = 1'b0;
	endtask

	task automatic test_output_backpressure();
		int i;
		stall_len = 200;
		for (i = 0; i < 40; i++) begin
			send_op(random_op(i < 20));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		steady = 1'b0;
		stall_len = 0;
		fails = 0;
		shadow_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_insert_positions();
		test_full_store();
		test_set_remove();
		test_random_walk(1060);
		test_output_backpressure();

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d operations: %0d rejected as full, %0d out of range.",
			n_ops, n_full, n_range);
		$display("The store peaked at %0d entries; %0d mismatches seen.",
			peak_count, fails);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
